[rtl/stun_mapped_address_parser_macros.svh]
// assertion macros shared by the stun mapped address parser rtl
`ifndef STUN_MAPPED_ADDRESS_PARSER_MACROS_SVH
`define STUN_MAPPED_ADDRESS_PARSER_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define SMAP_ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define SMAP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/smap_pkg.sv]
// shared types and constants of the stun mapped address parser
package smap_pkg;

  localparam int SMAP_COUNT_BITS = 16;

  localparam int unsigned HEADER_BYTES = 20;
  localparam int unsigned COOKIE_FIRST = 4;
  localparam int unsigned COOKIE_LAST  = 7;
  localparam logic [31:0] COOKIE       = 32'h2112A442;
  localparam logic [15:0] COOKIE_HIGH  = 16'h2112;
  localparam logic [7:0]  FAMILY_IPV4  = 8'h01;
  localparam logic [15:0] MIN_ADDR_LEN = 16'd8;

  localparam logic [15:0] XOR_TYPE_RESET   = 16'h0020;
  localparam logic [15:0] PLAIN_TYPE_RESET = 16'h0001;

  localparam logic KIND_XOR   = 1'b0;
  localparam logic KIND_PLAIN = 1'b1;

  typedef enum logic [1:0] {
    ST_FOUND      = 2'd0,
    ST_SHORT      = 2'd1,
    ST_BAD_COOKIE = 2'd2,
    ST_NO_ADDR    = 2'd3
  } status_t;

  typedef enum logic [0:0] {
    REG_XOR_TYPE   = 1'b0,
    REG_PLAIN_TYPE = 1'b1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    PH_HEADER   = 3'd0,
    PH_ATTR_HDR = 3'd1,
    PH_VALUE    = 3'd2,
    PH_PAD      = 3'd3,
    PH_DONE     = 3'd4
  } phase_t;

  typedef struct packed {
    status_t     status;
    logic        kind;
    logic [31:0] addr;
    logic [15:0] port;
  } smap_result_t;

  // cookie byte at header offset 4 + idx, most significant first
  function automatic logic [7:0] cookie_byte(input logic [1:0] idx);
    logic [7:0] b;
    unique case (idx)
      2'd0: b = COOKIE[31:24];
      2'd1: b = COOKIE[23:16];
      2'd2: b = COOKIE[15:8];
      2'd3: b = COOKIE[7:0];
      default: b = COOKIE[7:0];
    endcase
    return b;
  endfunction

endpackage

[rtl/smap_walker.sv]
// per-byte header check and attribute walk, holds the message state
module smap_walker #(
  parameter int COUNT_BITS = smap_pkg::SMAP_COUNT_BITS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step,
  input  logic [7:0]           data_byte,
  input  logic                 last_byte,
  input  logic [15:0]          xor_type,
  input  logic [15:0]          plain_type,
  output smap_pkg::smap_result_t result
);
  import smap_pkg::*;

  logic [COUNT_BITS-1:0] count_r, count_nxt;
  logic                  cookie_bad_r, cookie_bad_nxt;
  phase_t                phase_r, phase_nxt;
  logic [15:0]           type_r, type_nxt;
  logic [15:0]           len_r, len_nxt;
  logic [15:0]           offset_r, offset_nxt;
  logic [1:0]            pad_r, pad_nxt;
  logic [7:0]            family_r, family_nxt;
  logic [15:0]           port_r, port_nxt;
  logic [31:0]           addr_r, addr_nxt;
  logic                  kind_r, kind_nxt;

  logic [COUNT_BITS-1:0] pos;
  logic [15:0]           off_inc;
  logic [15:0]           len_now;
  logic [1:0]            pad_calc;
  logic                  is_xor, is_plain;

  always_comb begin
    pos      = count_r;
    off_inc  = offset_r + 16'd1;
    len_now  = {len_r[15:8], data_byte};
    is_xor   = (type_r == xor_type);
    is_plain = (type_r == plain_type);
    pad_calc = 2'(2'd0 - len_r[1:0]);

    count_nxt      = (count_r != '1) ? count_r + 1'b1 : count_r;
    cookie_bad_nxt = cookie_bad_r;
    phase_nxt      = phase_r;
    type_nxt       = type_r;
    len_nxt        = len_r;
    offset_nxt     = offset_r;
    pad_nxt        = pad_r;
    family_nxt     = family_r;
    port_nxt       = port_r;
    addr_nxt       = addr_r;
    kind_nxt       = kind_r;

    unique case (phase_r)
      PH_HEADER: begin
        if (pos >= COUNT_BITS'(COOKIE_FIRST) && pos <= COUNT_BITS'(COOKIE_LAST)
            && data_byte != cookie_byte(pos[1:0])) begin
          cookie_bad_nxt = 1'b1;
        end
        if (pos >= COUNT_BITS'(HEADER_BYTES - 1)) begin
          phase_nxt  = PH_ATTR_HDR;
          offset_nxt = '0;
        end
      end
      PH_ATTR_HDR: begin
        offset_nxt = off_inc;
        unique case (offset_r[1:0])
          2'd0: type_nxt = {data_byte, 8'd0};
          2'd1: type_nxt = {type_r[15:8], data_byte};
          2'd2: len_nxt  = {data_byte, 8'd0};
          2'd3: begin
            len_nxt    = len_now;
            offset_nxt = '0;
            family_nxt = '0;
            port_nxt   = '0;
            addr_nxt   = '0;
            // an empty attribute has no family byte, so it never matches
            phase_nxt  = (len_now == 16'd0) ? PH_ATTR_HDR : PH_VALUE;
          end
          default: ;
        endcase
      end
      PH_VALUE: begin
        if (offset_r == 16'd1) begin
          family_nxt = data_byte;
        end else if (offset_r == 16'd2 || offset_r == 16'd3) begin
          port_nxt = {port_r[7:0], data_byte};
        end else if (offset_r >= 16'd4 && offset_r <= 16'd7) begin
          addr_nxt = {addr_r[23:0], data_byte};
        end
        offset_nxt = off_inc;
        if (off_inc >= len_r) begin
          if ((is_xor || is_plain) && len_r >= MIN_ADDR_LEN
              && family_nxt == FAMILY_IPV4) begin
            kind_nxt  = is_xor ? KIND_XOR : KIND_PLAIN;
            phase_nxt = PH_DONE;
          end else begin
            pad_nxt    = pad_calc;
            phase_nxt  = (pad_calc != 2'd0) ? PH_PAD : PH_ATTR_HDR;
            offset_nxt = '0;
          end
        end
      end
      PH_PAD: begin
        pad_nxt = pad_r - 2'd1;
        if (pad_r == 2'd1) begin
          phase_nxt  = PH_ATTR_HDR;
          offset_nxt = '0;
        end
      end
      PH_DONE: ;
      default: ;
    endcase

    // result as seen after this byte
    result.kind = KIND_XOR;
    result.addr = '0;
    result.port = '0;
    if (count_nxt < COUNT_BITS'(HEADER_BYTES)) begin
      result.status = ST_SHORT;
    end else if (cookie_bad_nxt) begin
      result.status = ST_BAD_COOKIE;
    end else if (phase_nxt == PH_DONE) begin
      result.status = ST_FOUND;
      result.kind   = kind_nxt;
      if (kind_nxt == KIND_XOR) begin
        result.addr = addr_nxt ^ COOKIE;
        result.port = port_nxt ^ COOKIE_HIGH;
      end else begin
        result.addr = addr_nxt;
        result.port = port_nxt;
      end
    end else begin
      result.status = ST_NO_ADDR;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (step && last_byte)) begin
      count_r      <= '0;
      cookie_bad_r <= 1'b0;
      phase_r      <= PH_HEADER;
      type_r       <= '0;
      len_r        <= '0;
      offset_r     <= '0;
      pad_r        <= '0;
      family_r     <= '0;
      port_r       <= '0;
      addr_r       <= '0;
      kind_r       <= 1'b0;
    end else if (step) begin
      count_r      <= count_nxt;
      cookie_bad_r <= cookie_bad_nxt;
      phase_r      <= phase_nxt;
      type_r       <= type_nxt;
      len_r        <= len_nxt;
      offset_r     <= offset_nxt;
      pad_r        <= pad_nxt;
      family_r     <= family_nxt;
      port_r       <= port_nxt;
      addr_r       <= addr_nxt;
      kind_r       <= kind_nxt;
    end
  end

endmodule

[rtl/stun_mapped_address_parser.sv]
// top level of the stun mapped address parser: input register, walker, result register
// Takes a STUN response one byte per item, the final byte flagged by in_last_byte, and
// gives one result item for each message: status, address kind, IPv4 address and port,
// with the XOR kind already un-XORed against the magic cookie. Sustained rate is one byte
// per clock; input is held off only while a final byte waits behind a result not yet
// taken. A byte is held in the input register, then the walker updates its state from
// it; the result of a message and out_valid are loaded in the cycle its final byte is
// processed. The attribute type codes are set through the cfg port; the user must do
// so while no message is in flight, as the block itself does not enforce it.
module stun_mapped_address_parser #(
  parameter int COUNT_BITS = smap_pkg::SMAP_COUNT_BITS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           in_data_byte,
  input  logic                 in_last_byte,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [1:0]           out_status,
  output logic                 out_address_kind,
  output logic [31:0]          out_public_address,
  output logic [15:0]          out_mapped_port,
  input  logic                 cfg_we,
  input  smap_pkg::cfg_reg_t   cfg_index,
  input  logic [15:0]          cfg_wdata
);
  import smap_pkg::*;
  `include "stun_mapped_address_parser_macros.svh"

  logic         s1_valid_r, s1_valid_nxt;
  logic [7:0]   s1_byte_r;
  logic         s1_last_r;
  logic         proc_go;
  logic         out_valid_r, out_valid_nxt;
  logic         load_out;
  smap_result_t res_r;
  smap_result_t walk_res;
  logic [15:0]  xor_type_r;
  logic [15:0]  plain_type_r;

  // a non-final byte never waits on the output side
  assign proc_go  = s1_valid_r && (!s1_last_r || !out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || proc_go;
  assign load_out = proc_go && s1_last_r;

  always_comb begin
    s1_valid_nxt  = (in_valid && in_ready) ? 1'b1 : (proc_go ? 1'b0 : s1_valid_r);
    out_valid_nxt = load_out ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte_r <= in_data_byte;
      s1_last_r <= in_last_byte;
    end
    if (load_out) begin
      res_r <= walk_res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      xor_type_r   <= XOR_TYPE_RESET;
      plain_type_r <= PLAIN_TYPE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_XOR_TYPE:   xor_type_r   <= cfg_wdata;
        REG_PLAIN_TYPE: plain_type_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  smap_walker #(
    .COUNT_BITS (COUNT_BITS)
  ) u_walker (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (proc_go),
    .data_byte  (s1_byte_r),
    .last_byte  (s1_last_r),
    .xor_type   (xor_type_r),
    .plain_type (plain_type_r),
    .result     (walk_res)
  );

  assign out_valid          = out_valid_r;
  assign out_status         = res_r.status;
  assign out_address_kind   = res_r.kind;
  assign out_public_address = res_r.addr;
  assign out_mapped_port    = res_r.port;

  `SMAP_ASSERT_IMPLIES(a_zero_unless_found, out_valid_r && res_r.status != ST_FOUND,
    res_r.kind == KIND_XOR && res_r.addr == 32'd0 && res_r.port == 16'd0,
    "fields not zero on a failed result")
  `SMAP_ASSERT_NEXT(a_final_loads_out, load_out, out_valid_r,
    "final byte did not produce a result")
  `SMAP_ASSERT_NEXT(a_held_byte_stays, s1_valid_r && !proc_go,
    s1_valid_r && $stable(s1_byte_r) && $stable(s1_last_r), "held byte lost")
  `SMAP_ASSERT_IMPLIES(a_stall_reason, !in_ready,
    s1_valid_r && s1_last_r && out_valid_r && !out_ready,
    "input stalled without a waiting result")

endmodule

[verif/tb_top.sv]
// testbench for the stun mapped address parser: byte stream in, one checked result per message
module tb_top;
  import smap_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int LONG_HOLD = 300;
  localparam longint unsigned COUNT_MAX = (64'd1 << SMAP_COUNT_BITS) - 64'd1;

  typedef struct {
    logic [7:0] data;
    logic       last;
  } wire_byte_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_data_byte = 8'h00;
  logic        in_last_byte = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  out_status;
  logic        out_address_kind;
  logic [31:0] out_public_address;
  logic [15:0] out_mapped_port;
  logic        cfg_we = 1'b0;
  cfg_reg_t    cfg_index = REG_XOR_TYPE;
  logic [15:0] cfg_wdata = 16'h0000;

  stun_mapped_address_parser dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data_byte(in_data_byte),
    .in_last_byte(in_last_byte),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_status(out_status),
    .out_address_kind(out_address_kind),
    .out_public_address(out_public_address),
    .out_mapped_port(out_mapped_port),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // parser state mirrored on the testbench side
  logic [15:0]       xor_code = XOR_TYPE_RESET;
  logic [15:0]       plain_code = PLAIN_TYPE_RESET;
  longint unsigned   rx_count;
  logic              hdr_cookie_bad;
  phase_t            walk;
  logic [15:0]       at_type;
  logic [15:0]       at_len;
  int unsigned       at_off;
  logic [1:0]        pad_count;
  logic [7:0]        fam;
  logic [15:0]       port_acc;
  logic [31:0]       addr_acc;
  logic              hit_kind;
  logic              hit_locked;

  smap_result_t      answer_q[$];
  smap_result_t      want_res;
  wire_byte_t        wire_bytes[$];
  wire_byte_t        tx_item;
  logic [7:0]        msg_buf[$];

  int  fails = 0;
  int  cycles = 0;
  bit  in_taken = 0;
  bit  tx_calm = 0;
  bit  rx_calm = 0;
  bit  tx_fast = 0;
  int  tx_gap = 0;
  int  rx_stall = 0;
  int  rx_hold = 0;
  int  holds_asked = 0;
  int  holds_done = 0;

  function void clear_walk();
    rx_count = 0;
    hdr_cookie_bad = 1'b0;
    walk = PH_HEADER;
    at_type = '0;
    at_len = '0;
    at_off = 0;
    pad_count = '0;
    fam = '0;
    port_acc = '0;
    addr_acc = '0;
    hit_kind = KIND_XOR;
    hit_locked = 1'b0;
  endfunction

  // whole attribute value seen: either it is the address we want or we skip its padding
  function void close_attr();
    logic is_x;
    logic is_p;
    is_x = (at_type == xor_code);
    is_p = (at_type == plain_code);
    if ((is_x || is_p) && at_len >= MIN_ADDR_LEN && fam == FAMILY_IPV4) begin
      hit_locked = 1'b1;
      hit_kind = is_x ? KIND_XOR : KIND_PLAIN;
      walk = PH_DONE;
    end else begin
      pad_count = 2'd0 - at_len[1:0];
      walk = (pad_count != 2'd0) ? PH_PAD : PH_ATTR_HDR;
      at_off = 0;
    end
  endfunction

  function void parse_byte(input logic [7:0] b, input logic last);
    longint unsigned pos;
    smap_result_t r;
    pos = rx_count;
    if (rx_count < COUNT_MAX) rx_count++;
    case (walk)
      PH_HEADER: begin
        if (pos >= COOKIE_FIRST && pos <= COOKIE_LAST &&
            b != 8'(COOKIE >> (8 * (COOKIE_LAST - pos))))
          hdr_cookie_bad = 1'b1;
        if (pos >= HEADER_BYTES - 1) begin
          walk = PH_ATTR_HDR;
          at_off = 0;
        end
      end
      PH_ATTR_HDR: begin
        case (at_off)
          0: at_type = {b, 8'h00};
          1: at_type = at_type | {8'h00, b};
          2: at_len = {b, 8'h00};
          default: at_len = at_len | {8'h00, b};
        endcase
        at_off++;
        if (at_off >= 4) begin
          at_off = 0;
          fam = '0;
          port_acc = '0;
          addr_acc = '0;
          if (at_len == 16'd0) close_attr();
          else walk = PH_VALUE;
        end
      end
      PH_VALUE: begin
        if (at_off == 1) fam = b;
        else if (at_off == 2 || at_off == 3) port_acc = {port_acc[7:0], b};
        else if (at_off >= 4 && at_off <= 7) addr_acc = {addr_acc[23:0], b};
        at_off++;
        if (at_off >= at_len) close_attr();
      end
      PH_PAD: begin
        if (pad_count > 2'd0) pad_count--;
        if (pad_count == 2'd0) begin
          walk = PH_ATTR_HDR;
          at_off = 0;
        end
      end
      default: ;
    endcase
    if (last) begin
      r.kind = KIND_XOR;
      r.addr = '0;
      r.port = '0;
      if (rx_count < HEADER_BYTES) begin
        r.status = ST_SHORT;
      end else if (hdr_cookie_bad) begin
        r.status = ST_BAD_COOKIE;
      end else if (hit_locked) begin
        r.status = ST_FOUND;
        r.kind = hit_kind;
        r.addr = (hit_kind == KIND_XOR) ? addr_acc ^ COOKIE : addr_acc;
        r.port = (hit_kind == KIND_XOR) ? port_acc ^ COOKIE_HIGH : port_acc;
      end else begin
        r.status = ST_NO_ADDR;
      end
      answer_q.insert(answer_q.size(), r);
      clear_walk();
    end
  endfunction

  initial clear_walk();

  // most gaps short, a few long
  function int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  function logic [15:0] other_code();
    logic [15:0] c;
    c = 16'($urandom);
    while (c == xor_code || c == plain_code) c = 16'($urandom);
    return c;
  endfunction

  // append one byte to the message being built
  function void add_byte(input logic [7:0] b);
    msg_buf.insert(msg_buf.size(), b);
  endfunction

  function void put_header(input bit good_cookie);
    logic [7:0] b;
    int bad_at;
    bad_at = $urandom_range(0, 3);
    add_byte(8'h01);
    add_byte(8'h01);
    add_byte(8'($urandom));
    add_byte(8'($urandom));
    for (int i = 0; i < 4; i++) begin
      b = 8'(COOKIE >> (24 - 8 * i));
      if (!good_cookie && i == bad_at) b = b ^ 8'($urandom_range(1, 255));
      add_byte(b);
    end
    for (int i = 0; i < 12; i++) add_byte(8'($urandom));
  endfunction

  function void put_attr(input logic [15:0] typ, input logic [15:0] len,
                         input logic [7:0] family, input logic [15:0] port,
                         input logic [31:0] addr, input bit with_pad);
    logic [7:0] b;
    add_byte(typ[15:8]);
    add_byte(typ[7:0]);
    add_byte(len[15:8]);
    add_byte(len[7:0]);
    for (int i = 0; i < int'(len); i++) begin
      case (i)
        1: b = family;
        2: b = port[15:8];
        3: b = port[7:0];
        4: b = addr[31:24];
        5: b = addr[23:16];
        6: b = addr[15:8];
        7: b = addr[7:0];
        default: b = 8'($urandom);
      endcase
      add_byte(b);
    end
    if (with_pad)
      for (int i = 0; i < int'(2'(2'd0 - len[1:0])); i++) add_byte(8'($urandom));
  endfunction

  function void put_random_attr();
    int k;
    logic [15:0] typ;
    logic [15:0] len;
    k = $urandom_range(0, 9);
    if (k < 4) typ = xor_code;
    else if (k < 7) typ = plain_code;
    else if (k < 9) typ = other_code();
    else typ = 16'($urandom);
    k = $urandom_range(0, 9);
    if (k < 6) len = 16'd8;
    else if (k < 8) len = 16'($urandom_range(9, 16));
    else len = 16'($urandom_range(0, 7));
    put_attr(typ, len, ($urandom_range(0, 7) == 0) ? 8'($urandom) : FAMILY_IPV4,
             16'($urandom), $urandom, $urandom_range(0, 9) != 0);
  endfunction

  function void random_message();
    int sel;
    int cut;
    sel = $urandom_range(0, 99);
    if (sel < 75) begin
      put_header($urandom_range(0, 9) != 0);
      repeat ($urandom_range(0, 4)) put_random_attr();
      if ($urandom_range(0, 9) == 0) begin
        cut = $urandom_range(1, msg_buf.size());
        while (msg_buf.size() > cut) void'(msg_buf.pop_back());
      end
      if ($urandom_range(0, 9) == 0)
        repeat ($urandom_range(1, 6)) add_byte(8'($urandom));
    end else if (sel < 88) begin
      if ($urandom_range(0, 1) == 1) begin
        put_header(1);
        cut = $urandom_range(1, HEADER_BYTES - 1);
        while (msg_buf.size() > cut) void'(msg_buf.pop_back());
      end else begin
        repeat ($urandom_range(1, HEADER_BYTES - 1)) add_byte(8'($urandom));
      end
    end else begin
      repeat ($urandom_range(20, 48)) add_byte(8'($urandom));
    end
  endfunction

  function void send_msg();
    wire_byte_t wb;
    for (int i = 0; i < msg_buf.size(); i++) begin
      wb.data = msg_buf[i];
      wb.last = (i == msg_buf.size() - 1);
      wire_bytes.insert(wire_bytes.size(), wb);
    end
    msg_buf.delete();
  endfunction

  task automatic random_phase(input int n_bytes);
    int sent;
    sent = 0;
    while (sent < n_bytes) begin
      random_message();
      sent += msg_buf.size();
      send_msg();
    end
  endtask

  task automatic wait_idle();
    while (wire_bytes.size() != 0 || in_valid || answer_q.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  // called at a falling edge with the parser idle
  task automatic set_type_codes(input logic [15:0] x_code, input logic [15:0] p_code);
    cfg_we <= 1'b1;
    cfg_index <= REG_XOR_TYPE;
    cfg_wdata <= x_code;
    @(negedge clk);
    cfg_index <= REG_PLAIN_TYPE;
    cfg_wdata <= p_code;
    @(negedge clk);
    cfg_we <= 1'b0;
    xor_code = x_code;
    plain_code = p_code;
  endtask

  // input side: sample the handshake at the rising edge
  always @(posedge clk) begin
    in_taken = rst_n && in_valid && in_ready;
    if (in_taken) parse_byte(in_data_byte, in_last_byte);
  end

  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_taken)) begin
      if ($urandom_range(0, 199) == 0) tx_calm = !tx_calm;
      if (tx_gap > 0) begin
        tx_gap--;
        in_valid <= 1'b0;
      end else if (wire_bytes.size() > 0) begin
        tx_item = wire_bytes.pop_front();
        in_data_byte <= tx_item.data;
        in_last_byte <= tx_item.last;
        in_valid <= 1'b1;
        tx_gap = (tx_calm || tx_fast) ? 0 : pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result side: random stalls plus the long hold-offs that are asked for
  always @(negedge clk) begin
    if (rst_n) begin
      if ($urandom_range(0, 199) == 0) rx_calm = !rx_calm;
      if (rx_hold > 0) begin
        rx_hold--;
        out_ready <= 1'b0;
      end else if (holds_done < holds_asked) begin
        holds_done++;
        rx_hold = LONG_HOLD - 1;
        out_ready <= 1'b0;
      end else if (rx_stall > 0) begin
        rx_stall--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        rx_stall = rx_calm ? 0 : pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (answer_q.size() == 0) begin
        $error("result item with no message pending");
        fails++;
      end else begin
        want_res = answer_q.pop_front();
        if (out_status !== want_res.status) begin
          $error("status: expected %0d got %0d", want_res.status, out_status);
          fails++;
        end
        if (out_address_kind !== want_res.kind) begin
          $error("address_kind: expected %0d got %0d", want_res.kind, out_address_kind);
          fails++;
        end
        if (out_public_address !== want_res.addr) begin
          $error("public_address: expected %08h got %08h", want_res.addr, out_public_address);
          fails++;
        end
        if (out_mapped_port !== want_res.port) begin
          $error("mapped_port: expected %04h got %04h", want_res.port, out_mapped_port);
          fails++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // short message, one byte
    add_byte(8'($urandom));
    send_msg();
    // one byte short of a header
    put_header(1);
    void'(msg_buf.pop_back());
    send_msg();
    // short wins over a bad cookie
    put_header(0);
    void'(msg_buf.pop_back());
    send_msg();
    // bare header
    put_header(1);
    send_msg();
    // bad cookie wins over a usable address
    put_header(0);
    put_attr(xor_code, 16'd8, FAMILY_IPV4, 16'h1234, 32'h0a000001, 1);
    send_msg();
    // field extremes, both kinds
    put_header(1);
    put_attr(xor_code, 16'd8, FAMILY_IPV4, 16'hFFFF, 32'hFFFFFFFF, 1);
    send_msg();
    put_header(1);
    put_attr(plain_code, 16'd8, FAMILY_IPV4, 16'h0000, 32'h00000000, 1);
    send_msg();
    put_header(1);
    put_attr(xor_code, 16'd8, FAMILY_IPV4, 16'h0000, 32'h00000000, 1);
    send_msg();
    put_header(1);
    put_attr(plain_code, 16'd8, FAMILY_IPV4, 16'hFFFF, 32'hFFFFFFFF, 1);
    send_msg();
    // skipped attributes with padding, too short a value, then a long plain one
    put_header(1);
    put_attr(other_code(), 16'd5, 8'h00, 16'h0, 32'h0, 1);
    put_attr(xor_code, 16'd7, FAMILY_IPV4, 16'h4321, 32'hc0a80101, 1);
    put_attr(plain_code, 16'd12, FAMILY_IPV4, 16'hbeef, 32'h8badf00d, 1);
    send_msg();
    // ipv6 family, empty attribute, a match, then bytes that must be ignored
    put_header(1);
    put_attr(xor_code, 16'd8, 8'h02, 16'h1111, 32'h22222222, 1);
    put_attr(other_code(), 16'd0, 8'h00, 16'h0, 32'h0, 1);
    put_attr(xor_code, 16'd8, FAMILY_IPV4, 16'h5a5a, 32'ha5a5a5a5, 1);
    put_attr(plain_code, 16'd8, FAMILY_IPV4, 16'h7777, 32'h01020304, 1);
    repeat (3) add_byte(8'($urandom));
    send_msg();
    // value cut off by the end of the message
    put_header(1);
    put_attr(xor_code, 16'd8, FAMILY_IPV4, 16'h9999, 32'h12345678, 1);
    repeat (3) void'(msg_buf.pop_back());
    send_msg();
    // attribute header cut off
    put_header(1);
    add_byte(xor_code[15:8]);
    add_byte(xor_code[7:0]);
    send_msg();
    // padding cut off, without and with a match
    put_header(1);
    put_attr(other_code(), 16'd1, 8'h00, 16'h0, 32'h0, 0);
    send_msg();
    put_header(1);
    put_attr(plain_code, 16'd9, FAMILY_IPV4, 16'h0bad, 32'hcafe0001, 0);
    send_msg();
    // long skipped attribute before the address, sent back to back
    put_header(1);
    put_attr(other_code(), 16'd200, 8'h00, 16'h0, 32'h0, 1);
    put_attr(xor_code, 16'd8, FAMILY_IPV4, 16'($urandom), $urandom, 1);
    tx_fast = 1;
    send_msg();
    wait_idle();
    tx_fast = 0;

    set_type_codes(16'hFFFF, 16'h0000);
    random_phase(240);
    wait_idle();

    // same code in both registers: xor kind takes it
    set_type_codes(16'h0020, 16'h0020);
    random_phase(200);
    wait_idle();

    set_type_codes(16'($urandom), 16'($urandom));
    random_phase(240);
    wait_idle();

    set_type_codes(XOR_TYPE_RESET, PLAIN_TYPE_RESET);
    // results back up behind a receiver that holds off for a long while
    tx_fast = 1;
    holds_asked++;
    repeat (12) begin
      repeat ($urandom_range(1, 3)) add_byte(8'($urandom));
      send_msg();
    end
    wait_idle();
    tx_fast = 0;
    random_phase(240);
    wait_idle();

    if (fails == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule

[sim.f]
+incdir+rtl
rtl/smap_pkg.sv
rtl/smap_walker.sv
rtl/stun_mapped_address_parser.sv
verif/tb_top.sv
